FILE: hdl/efla_pkg.sv
// Shared types and constants of the best-fit heap allocator.
// Depends on nothing; the core, the checker and the bench files import it.
`default_nettype none

package efla_pkg;

  // Default heap size in bytes and default minimum growth of the heap.
  localparam int unsigned DEFAULT_HEAP_BYTES = 65536;
  localparam int unsigned DEFAULT_CHUNK      = 1 << 12;

  // Boundary tag fields.
  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
  localparam logic [31:0] MIN_BLOCK = 32'd16;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OOM  = 2'd2;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE,
    ST_WCHK, ST_WTAG, ST_WNXT, ST_GROW, ST_WQ,
    ST_F0, ST_F1,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_MCONT, ST_MRM2, ST_MPUSH, ST_MDONE,
    ST_C0, ST_C1, ST_CCONT,
    ST_R0, ST_R1, ST_R2, ST_R3,
    ST_V0, ST_V1, ST_V2, ST_V3, ST_V4, ST_V5,
    ST_P0, ST_P1, ST_P2,
    ST_FIN
  } st_e;

  // One pending word write of a tag update.
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
  } wq_t;

endpackage

`default_nettype wire

FILE: hdl/efla_if.sv
// Channel interfaces of the allocator: configuration, request and result.
// Depends on nothing; each carries valid, ready and its payload.
`default_nettype none

interface efla_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] grow_chunk_bytes;
  modport source (output valid, output grow_chunk_bytes, input ready);
  modport sink (input valid, input grow_chunk_bytes, output ready);
endinterface

interface efla_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] request_bytes;
  logic [15:0] block_address;
  modport source (output valid, output opcode, output request_bytes,
                  output block_address, input ready);
  modport sink (input valid, input opcode, input request_bytes,
                input block_address, output ready);
endinterface

interface efla_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_address;
  logic [1:0]  status;
  modport source (output valid, output payload_address, output status, input ready);
  modport sink (input valid, input payload_address, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/explicit_free_list_best_fit_allocator_core.sv
// Best-fit heap allocator with boundary tags and a doubly linked free list.
// Depends on efla_pkg and the channel interfaces in efla_if.sv.
`default_nettype none

// The heap lives in one single-port synchronous word memory of HEAP_BYTES/4
// words (capped at 16384); every tag and link access is a read or write of
// that memory, so one item takes a data-dependent number of cycles. After the
// request is taken, an allocation walks the free list for the best fit,
// reading the header and link of each node, and then carves the chosen
// block, first growing the heap and coalescing when no block fits; a free
// reads and checks the header and, if it is valid, clears the flag and
// coalesces, else it is ignored. The memory port takes one access per cycle.
// After reset a clearing pass writes the initial heap image, during which no
// request is taken; configuration transfers are taken at any time. A result
// waits in an output register and the next request is taken while it waits.
module explicit_free_list_best_fit_allocator_core
  import efla_pkg::*;
#(
  parameter int unsigned HEAP_BYTES = DEFAULT_HEAP_BYTES
) (
  input  logic clk_i,
  input  logic rst_ni,
  efla_cfg_if.sink   cfg_i,
  efla_in_if.sink    in_i,
  efla_out_if.source out_o
);

  localparam int unsigned HeapCap   = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
  localparam int unsigned HeapWords = HeapCap / 4;
  localparam int unsigned AddrW     = $clog2(HeapWords);
  localparam int unsigned InitFit   = (HeapCap - 16) / 8 * 8;
  localparam int unsigned InitChunk = (InitFit < DEFAULT_CHUNK) ? InitFit : DEFAULT_CHUNK;
  localparam logic [31:0] CapW      = 32'(HeapCap);
  localparam logic [31:0] InitW     = 32'(InitChunk);

  // Initial heap image: prologue tags, one free block, epilogue header.
  function automatic logic [31:0] init_word(input logic [AddrW-1:0] idx);
    logic [31:0] a;
    a = {{(30 - AddrW){1'b0}}, idx, 2'b00};
    if (a == 32'd4 || a == 32'd8) begin
      init_word = 32'd8 | ALLOC_BIT;
    end else if (a == 32'd12 || a == 32'd8 + InitW) begin
      init_word = InitW;
    end else if (a == 32'd12 + InitW) begin
      init_word = ALLOC_BIT;
    end else begin
      init_word = '0;
    end
  endfunction

  // Control state.
  st_e             state_q, state_d, ret_q, ret_d;
  logic [31:0]     head_q, head_d;
  logic [16:0]     heap_end_q, heap_end_d;
  logic [16:0]     chunk_q;
  logic            out_valid_q, out_valid_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  // Datapath registers.
  logic            op_q, op_d;
  logic [31:0]     need_q, need_d, addr_q, addr_d;
  logic [31:0]     p_q, p_d, best_q, best_d, bd_q, bd_d;
  logic [AddrW:0]  n_q, n_d;
  logic [31:0]     mbp_q, mbp_d, size_q, size_d, pfoot_q, pfoot_d, nhdr_q, nhdr_d;
  logic [31:0]     nextbp_q, nextbp_d, prevbp_q, prevbp_d, mres_q, mres_d;
  logic [1:0]      mcase_q, mcase_d;
  logic [31:0]     cbp_q, cbp_d;
  logic            split_q, split_d;
  logic [31:0]     lx_q, lx_d, ln_q, ln_d, nx_q, nx_d, pv_q, pv_d, first_q, first_d;
  wq_t [3:0]       wq_q, wq_d;
  logic [2:0]      wq_cnt_q, wq_cnt_d;
  logic [1:0]      wq_idx_q, wq_idx_d;
  logic [15:0]     res_q, res_d, out_addr_q, out_addr_d;
  logic [1:0]      stat_q, stat_d, out_stat_q, out_stat_d;

  // Memory and its port.
  logic [31:0]     heap_mem [HeapWords];
  logic [31:0]     rdata_q;
  logic            rd_ok_q;
  logic [31:0]     rd_val;
  logic [31:0]     mem_a, mem_wd, port_wd;
  logic            mem_we, mem_in_range, port_we;
  logic [AddrW-1:0] port_idx;

  // Helper values.
  logic [31:0]     req_need, grow_e, grow_amt, he32, tsize, diff, ftotal;
  logic [31:0]     chunk32;
  logic            free_ok;

  assign rd_val  = rd_ok_q ? rdata_q : '0;
  assign he32    = {15'b0, heap_end_q};
  assign chunk32 = {15'b0, chunk_q};
  assign tsize   = rd_val & SIZE_MASK;
  assign diff    = tsize - need_q;

  // Block size of a request and the growth amount of the heap.
  assign req_need = (in_i.request_bytes <= 16'd8) ? MIN_BLOCK :
                    (({16'b0, in_i.request_bytes} + 32'd15) & SIZE_MASK);
  assign grow_e   = (need_q > chunk32) ? need_q : chunk32;
  assign grow_amt = (((grow_e >> 2) + 32'd1) & ~32'd1) << 2;

  // Validity of a free request against its header.
  assign free_ok = (addr_q[2:0] == 3'b000) && (addr_q >= 32'd16) && (addr_q < he32) &&
                   rd_val[0] && (tsize >= MIN_BLOCK) &&
                   ((addr_q - 32'd4 + tsize) <= (he32 - 32'd4));
  assign ftotal  = size_q + (rd_val & SIZE_MASK);

  assign in_i.ready            = (state_q == ST_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign out_o.valid           = out_valid_q;
  assign out_o.payload_address = out_addr_q;
  assign out_o.status          = out_stat_q;

  // Next state and datapath updates of the sequencer.
  always_comb begin
    state_d = state_q; ret_d = ret_q; head_d = head_q; heap_end_d = heap_end_q;
    out_valid_d = out_valid_q; clr_cnt_d = clr_cnt_q;
    op_d = op_q; need_d = need_q; addr_d = addr_q; p_d = p_q; best_d = best_q; bd_d = bd_q;
    n_d = n_q; mbp_d = mbp_q; size_d = size_q; pfoot_d = pfoot_q; nhdr_d = nhdr_q;
    nextbp_d = nextbp_q; prevbp_d = prevbp_q; mres_d = mres_q; mcase_d = mcase_q;
    cbp_d = cbp_q; split_d = split_q; lx_d = lx_q; ln_d = ln_q; nx_d = nx_q; pv_d = pv_q;
    first_d = first_q; wq_d = wq_q; wq_cnt_d = wq_cnt_q; wq_idx_d = wq_idx_q;
    res_d = res_q; stat_d = stat_q; out_addr_d = out_addr_q; out_stat_d = out_stat_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(HeapWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d   = in_i.opcode;
          addr_d = {16'b0, in_i.block_address};
          res_d  = '0;
          stat_d = STATUS_OK;
          if (in_i.opcode == OP_FREE) begin
            state_d = ST_F0;
          end else if (in_i.request_bytes == 16'd0) begin
            stat_d  = STATUS_ZERO;
            state_d = ST_FIN;
          end else begin
            need_d  = req_need;
            p_d     = head_q;
            best_d  = '0;
            bd_d    = '1;
            n_d     = '0;
            state_d = ST_WCHK;
          end
        end
      end
      // Best-fit walk over the free list.
      ST_WCHK: begin
        if (p_q != '0 && n_q < (AddrW + 1)'(HeapWords)) begin
          state_d = ST_WTAG;
        end else if (best_q != '0) begin
          cbp_d   = best_q;
          state_d = ST_C0;
        end else begin
          state_d = ST_GROW;
        end
      end
      ST_WTAG: begin
        if (tsize >= need_q && diff < bd_q) begin
          best_d = p_q;
          bd_d   = diff;
        end
        state_d = ST_WNXT;
      end
      ST_WNXT: begin
        p_d     = rd_val;
        n_d     = n_q + 1'b1;
        state_d = ST_WCHK;
      end
      // Extend the heap end by a new free block and a fresh epilogue.
      ST_GROW: begin
        if (he32 + grow_amt > CapW) begin
          stat_d  = STATUS_OOM;
          state_d = ST_FIN;
        end else begin
          wq_d[0]    = '{addr: he32 - 32'd4, data: grow_amt};
          wq_d[1]    = '{addr: he32 + grow_amt - 32'd8, data: grow_amt};
          wq_d[2]    = '{addr: he32 + grow_amt - 32'd4, data: ALLOC_BIT};
          wq_cnt_d   = 3'd3;
          wq_idx_d   = '0;
          heap_end_d = heap_end_q + grow_amt[16:0];
          mbp_d      = he32;
          ret_d      = ST_M0;
          state_d    = ST_WQ;
        end
      end
      ST_WQ: begin
        if ({1'b0, wq_idx_q} == wq_cnt_q - 3'd1) begin
          state_d = ret_q;
        end else begin
          wq_idx_d = wq_idx_q + 1'b1;
        end
      end
      // Free: check the header, clear its flag, then coalesce.
      ST_F0: state_d = ST_F1;
      ST_F1: begin
        if (free_ok) begin
          wq_d[0]  = '{addr: addr_q - 32'd4, data: tsize};
          wq_d[1]  = '{addr: addr_q + tsize - 32'd8, data: tsize};
          wq_cnt_d = 3'd2;
          wq_idx_d = '0;
          mbp_d    = addr_q;
          ret_d    = ST_M0;
          state_d  = ST_WQ;
        end else begin
          state_d = ST_FIN;
        end
      end
      // Coalescing: read own size, previous footer, next header, previous header.
      ST_M0: state_d = ST_M1;
      ST_M1: begin
        size_d  = tsize;
        state_d = ST_M2;
      end
      ST_M2: begin
        pfoot_d  = rd_val;
        nextbp_d = mbp_q + size_q;
        state_d  = ST_M3;
      end
      ST_M3: begin
        nhdr_d   = rd_val;
        prevbp_d = mbp_q - (pfoot_q & SIZE_MASK);
        state_d  = ST_M4;
      end
      ST_M4: begin
        mcase_d  = {pfoot_q[0], nhdr_q[0]};
        wq_cnt_d = 3'd2;
        wq_idx_d = '0;
        ret_d    = ST_MCONT;
        state_d  = ST_WQ;
        case ({pfoot_q[0], nhdr_q[0]})
          2'b11: begin
            mres_d  = mbp_q;
            state_d = ST_MCONT;
          end
          2'b10: begin
            mres_d = mbp_q;
            wq_d[0] = '{addr: mbp_q - 32'd4, data: size_q + (nhdr_q & SIZE_MASK)};
            wq_d[1] = '{addr: mbp_q + size_q + (nhdr_q & SIZE_MASK) - 32'd8,
                        data: size_q + (nhdr_q & SIZE_MASK)};
          end
          2'b01: begin
            mres_d  = prevbp_q;
            wq_d[0] = '{addr: mbp_q + size_q - 32'd8, data: ftotal};
            wq_d[1] = '{addr: prevbp_q - 32'd4, data: ftotal};
          end
          default: begin
            mres_d  = prevbp_q;
            wq_d[0] = '{addr: prevbp_q - 32'd4, data: ftotal + (nhdr_q & SIZE_MASK)};
            wq_d[1] = '{addr: nextbp_q + (nhdr_q & SIZE_MASK) - 32'd8,
                        data: ftotal + (nhdr_q & SIZE_MASK)};
          end
        endcase
      end
      ST_MCONT: begin
        state_d = ST_R0;
        ret_d   = ST_MPUSH;
        case (mcase_q)
          2'b11: state_d = ST_MPUSH;
          2'b10: lx_d = nextbp_q;
          2'b01: lx_d = prevbp_q;
          default: begin
            lx_d  = nextbp_q;
            ret_d = ST_MRM2;
          end
        endcase
      end
      ST_MRM2: begin
        lx_d    = prevbp_q;
        ret_d   = ST_MPUSH;
        state_d = ST_R0;
      end
      ST_MPUSH: begin
        lx_d    = mres_q;
        ret_d   = ST_MDONE;
        state_d = ST_P0;
      end
      ST_MDONE: begin
        if (op_q == OP_ALLOC) begin
          cbp_d   = mres_q;
          state_d = ST_C0;
        end else begin
          state_d = ST_FIN;
        end
      end
      // Carve the chosen block, splitting off a free remainder if large enough.
      ST_C0: state_d = ST_C1;
      ST_C1: begin
        res_d    = cbp_q[15:0];
        wq_idx_d = '0;
        ret_d    = ST_CCONT;
        state_d  = ST_WQ;
        if (diff >= MIN_BLOCK) begin
          split_d  = 1'b1;
          wq_d[0]  = '{addr: cbp_q - 32'd4, data: need_q | ALLOC_BIT};
          wq_d[1]  = '{addr: cbp_q + need_q - 32'd8, data: need_q | ALLOC_BIT};
          wq_d[2]  = '{addr: cbp_q + need_q - 32'd4, data: diff};
          wq_d[3]  = '{addr: cbp_q + tsize - 32'd8, data: diff};
          wq_cnt_d = 3'd4;
        end else begin
          split_d  = 1'b0;
          wq_d[0]  = '{addr: cbp_q - 32'd4, data: tsize | ALLOC_BIT};
          wq_d[1]  = '{addr: cbp_q + tsize - 32'd8, data: tsize | ALLOC_BIT};
          wq_cnt_d = 3'd2;
        end
      end
      ST_CCONT: begin
        lx_d    = cbp_q;
        ln_d    = cbp_q + need_q;
        ret_d   = ST_FIN;
        state_d = split_q ? ST_V0 : ST_R0;
      end
      // Unlink a block from the free list.
      ST_R0: state_d = ST_R1;
      ST_R1: begin
        nx_d    = rd_val;
        state_d = ST_R2;
      end
      ST_R2: begin
        pv_d = rd_val;
        if (rd_val == '0) begin
          head_d = nx_q;
        end
        state_d = ST_R3;
      end
      ST_R3: state_d = ret_q;
      // Move a free-list entry to the remainder of a split block.
      ST_V0: state_d = ST_V1;
      ST_V1: begin
        nx_d    = rd_val;
        state_d = ST_V2;
      end
      ST_V2: begin
        pv_d    = rd_val;
        state_d = ST_V3;
      end
      ST_V3: state_d = ST_V4;
      ST_V4: begin
        if (pv_q == '0) begin
          head_d = ln_q;
        end
        state_d = ST_V5;
      end
      ST_V5: state_d = ret_q;
      // Push a block at the head of the free list.
      ST_P0: begin
        first_d = head_q;
        state_d = ST_P1;
      end
      ST_P1: state_d = ST_P2;
      ST_P2: begin
        head_d  = lx_q;
        state_d = ret_q;
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_q;
          out_stat_d  = stat_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory port: address, write enable and write data of each state.
  always_comb begin
    mem_a  = '0;
    mem_we = 1'b0;
    mem_wd = '0;
    case (state_q)
      ST_WCHK: mem_a = p_q - 32'd4;
      ST_WTAG: mem_a = p_q;
      ST_F0:   mem_a = addr_q - 32'd4;
      ST_M0:   mem_a = mbp_q - 32'd4;
      ST_M1:   mem_a = mbp_q - 32'd8;
      ST_M2:   mem_a = mbp_q + size_q - 32'd4;
      ST_M3:   mem_a = mbp_q - (pfoot_q & SIZE_MASK) - 32'd4;
      ST_C0:   mem_a = cbp_q - 32'd4;
      ST_R0, ST_V0: mem_a = lx_q;
      ST_R1, ST_V1: mem_a = lx_q + 32'd4;
      ST_R2: begin
        mem_we = (rd_val != '0);
        mem_a  = rd_val;
        mem_wd = nx_q;
      end
      ST_R3: begin
        mem_we = (nx_q != '0);
        mem_a  = nx_q + 32'd4;
        mem_wd = pv_q;
      end
      ST_V2: begin
        mem_we = 1'b1;
        mem_a  = ln_q;
        mem_wd = nx_q;
      end
      ST_V3: begin
        mem_we = 1'b1;
        mem_a  = ln_q + 32'd4;
        mem_wd = pv_q;
      end
      ST_V4: begin
        mem_we = (pv_q != '0);
        mem_a  = pv_q;
        mem_wd = ln_q;
      end
      ST_V5: begin
        mem_we = (nx_q != '0);
        mem_a  = nx_q + 32'd4;
        mem_wd = ln_q;
      end
      ST_P0: begin
        mem_we = 1'b1;
        mem_a  = lx_q;
        mem_wd = head_q;
      end
      ST_P1: begin
        mem_we = 1'b1;
        mem_a  = lx_q + 32'd4;
      end
      ST_P2: begin
        mem_we = (first_q != '0);
        mem_a  = first_q + 32'd4;
        mem_wd = lx_q;
      end
      ST_WQ: begin
        mem_we = 1'b1;
        mem_a  = wq_q[wq_idx_q].addr;
        mem_wd = wq_q[wq_idx_q].data;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Out-of-range words read as zero and writes to them are dropped.
  assign mem_in_range = (mem_a < CapW);
  assign port_idx     = (state_q == ST_CLEAR) ? clr_cnt_q : mem_a[AddrW+1:2];
  assign port_we      = (state_q == ST_CLEAR) || (mem_we && mem_in_range);
  assign port_wd      = (state_q == ST_CLEAR) ? init_word(clr_cnt_q) : mem_wd;

  // Heap memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (port_we) begin
      heap_mem[port_idx] <= port_wd;
    end
    rdata_q <= heap_mem[port_idx];
    rd_ok_q <= mem_in_range;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ret_q       <= ST_IDLE;
      head_q      <= 32'd16;
      heap_end_q  <= 17'(32'd16 + InitW);
      chunk_q     <= 17'(DEFAULT_CHUNK);
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      head_q      <= head_d;
      heap_end_q  <= heap_end_d;
      out_valid_q <= out_valid_d;
      clr_cnt_q   <= clr_cnt_d;
      if (cfg_i.valid) begin
        chunk_q <= cfg_i.grow_chunk_bytes;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q <= op_d; need_q <= need_d; addr_q <= addr_d; p_q <= p_d; best_q <= best_d;
    bd_q <= bd_d; n_q <= n_d; mbp_q <= mbp_d; size_q <= size_d; pfoot_q <= pfoot_d;
    nhdr_q <= nhdr_d; nextbp_q <= nextbp_d; prevbp_q <= prevbp_d; mres_q <= mres_d;
    mcase_q <= mcase_d; cbp_q <= cbp_d; split_q <= split_d; lx_q <= lx_d; ln_q <= ln_d;
    nx_q <= nx_d; pv_q <= pv_d; first_q <= first_d; wq_q <= wq_d; wq_cnt_q <= wq_cnt_d;
    wq_idx_q <= wq_idx_d; res_q <= res_d; stat_q <= stat_d;
    out_addr_q <= out_addr_d; out_stat_q <= out_stat_d;
  end

endmodule

`default_nettype wire

FILE: hdl/efla_checker.sv
// Port-level checks of the allocator, bound to its top level.
// Depends on efla_pkg and explicit_free_list_best_fit_allocator_core.
`default_nettype none

module efla_checker
  import efla_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_payload_address_i,
  input logic [1:0]  out_status_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before its transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_address_i) && $stable(out_status_i))
    else $error("result payload changed while stalled");

  // A failed allocation never carries an address.
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_ZERO || out_status_i == STATUS_OOM)
      |-> out_payload_address_i == 16'd0)
    else $error("failed allocation returned an address");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken while one is at work");

endmodule

bind explicit_free_list_best_fit_allocator_core efla_checker u_efla_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .out_payload_address_i (out_o.payload_address),
  .out_status_i          (out_o.status)
);

`default_nettype wire

FILE: tb/efla_checker.sv
// Scoreboard of the allocator bench: watches the three channels, predicts each result.
// Depends on efla_pkg and the channel interfaces in efla_if.sv.
`default_nettype none

module efla_scoreboard
  import efla_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  efla_cfg_if        cfg_ch,
  efla_in_if         in_ch,
  efla_out_if        out_ch,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP   = (DEFAULT_HEAP_BYTES < 65536) ? DEFAULT_HEAP_BYTES : 65536;
  localparam int unsigned WORDS = CAP / 4;
  localparam int unsigned FIRST_CHUNK =
    ((CAP - 16) / 8 * 8 < DEFAULT_CHUNK) ? (CAP - 16) / 8 * 8 : DEFAULT_CHUNK;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } alloc_result_t;

  // Private copy of the heap image and the allocator registers.
  bit [31:0]     heap_words [WORDS];
  int unsigned   list_head;
  int unsigned   heap_top;
  int unsigned   chunk_bytes;
  alloc_result_t result_q [$];
  int            fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic int unsigned heap_rd(int unsigned a);
    int unsigned i;
    i = a >> 2;
    return (i < WORDS) ? heap_words[i] : 0;
  endfunction

  function automatic void heap_wr(int unsigned a, int unsigned v);
    int unsigned i;
    i = a >> 2;
    if (i < WORDS) heap_words[i] = v;
  endfunction

  function automatic int unsigned tag_of(int unsigned a);
    return heap_rd(a) & SIZE_MASK;
  endfunction

  // Free list maintenance: push at the head, unlink, and move a node.
  function automatic void push_free(int unsigned bp);
    int unsigned first;
    first = list_head;
    heap_wr(bp, first);
    heap_wr(bp + 4, 0);
    if (first != 0) heap_wr(first + 4, bp);
    list_head = bp;
  endfunction

  function automatic void unlink_free(int unsigned bp);
    int unsigned nx, pv;
    nx = heap_rd(bp);
    pv = heap_rd(bp + 4);
    if (pv != 0) heap_wr(pv, nx);
    else list_head = nx;
    if (nx != 0) heap_wr(nx + 4, pv);
  endfunction

  function automatic void relink_free(int unsigned bp, int unsigned nb);
    int unsigned nx, pv;
    nx = heap_rd(bp);
    pv = heap_rd(bp + 4);
    heap_wr(nb, nx);
    heap_wr(nb + 4, pv);
    if (pv != 0) heap_wr(pv, nb);
    else list_head = nb;
    if (nx != 0) heap_wr(nx + 4, nb);
  endfunction

  // Coalescing of a freed block with its neighbours; returns the merged block.
  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned size, pfoot, prevbp, nextbp, nsize, total;
    bit prev_used, next_used;
    size      = tag_of(bp - 4);
    pfoot     = heap_rd(bp - 8);
    prevbp    = bp - (pfoot & SIZE_MASK);
    nextbp    = bp + size;
    prev_used = (pfoot & ALLOC_BIT) != 0;
    next_used = (heap_rd(nextbp - 4) & ALLOC_BIT) != 0;
    if (prev_used && next_used) begin
      push_free(bp);
      return bp;
    end
    if (prev_used) begin
      size += tag_of(nextbp - 4);
      heap_wr(bp - 4, size);
      heap_wr(bp + size - 8, size);
      unlink_free(nextbp);
      push_free(bp);
      return bp;
    end
    if (next_used) begin
      total = size + tag_of(prevbp - 4);
      heap_wr(bp + size - 8, total);
      heap_wr(prevbp - 4, total);
      unlink_free(prevbp);
      push_free(prevbp);
      return prevbp;
    end
    nsize = tag_of(nextbp - 4);
    total = size + tag_of(prevbp - 4) + nsize;
    heap_wr(prevbp - 4, total);
    heap_wr(nextbp + nsize - 8, total);
    unlink_free(nextbp);
    unlink_free(prevbp);
    push_free(prevbp);
    return prevbp;
  endfunction

  // Best-fit walk, bounded so that a corrupted list still ends.
  function automatic int unsigned find_best(int unsigned need);
    int unsigned best, best_diff, p, n, s;
    best = 0;
    best_diff = 32'hFFFF_FFFF;
    p = list_head;
    n = 0;
    while (p != 0 && n < WORDS) begin
      s = tag_of(p - 4);
      if (s >= need && (s - need) < best_diff) begin
        best = p;
        best_diff = s - need;
      end
      p = heap_rd(p);
      n++;
    end
    return best;
  endfunction

  function automatic void split_block(int unsigned bp, int unsigned need);
    int unsigned size, rest, nb;
    size = tag_of(bp - 4);
    if (size - need >= MIN_BLOCK) begin
      rest = size - need;
      nb   = bp + need;
      heap_wr(bp - 4, need | ALLOC_BIT);
      heap_wr(bp + need - 8, need | ALLOC_BIT);
      heap_wr(nb - 4, rest);
      heap_wr(nb + rest - 8, rest);
      relink_free(bp, nb);
    end else begin
      heap_wr(bp - 4, size | ALLOC_BIT);
      heap_wr(bp + size - 8, size | ALLOC_BIT);
      unlink_free(bp);
    end
  endfunction

  // Result of one request, with the heap updated as the block would.
  function automatic alloc_result_t predict_result(logic op, int unsigned req, int unsigned addr);
    alloc_result_t r;
    int unsigned need, bp, e, grow, nb, h, size;
    r = '0;
    r.status = STATUS_OK;
    if (op == OP_ALLOC) begin
      if (req == 0) begin
        r.status = STATUS_ZERO;
      end else begin
        need = (req <= 8) ? MIN_BLOCK : 8 * ((req + 15) / 8);
        bp = find_best(need);
        if (bp == 0) begin
          e = (need > chunk_bytes) ? need : chunk_bytes;
          grow = ((e >> 2) + 1) & ~32'd1;
          grow = grow << 2;
          if (heap_top + grow > CAP) begin
            r.status = STATUS_OOM;
          end else begin
            nb = heap_top;
            heap_wr(nb - 4, grow);
            heap_wr(nb + grow - 8, grow);
            heap_wr(nb + grow - 4, ALLOC_BIT);
            heap_top = nb + grow;
            bp = coalesce(nb);
          end
        end
        if (bp != 0) begin
          split_block(bp, need);
          r.payload_address = bp[15:0];
        end
      end
    end else begin
      h = heap_rd(addr - 4);
      size = h & SIZE_MASK;
      if ((addr & 7) == 0 && addr >= 16 && addr < heap_top && (h & ALLOC_BIT) != 0 &&
          size >= MIN_BLOCK && addr - 4 + size <= heap_top - 4) begin
        heap_wr(addr - 4, size);
        heap_wr(addr + size - 8, size);
        void'(coalesce(addr));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  // Watch the channels: configuration and request transfers update the
  // prediction, result transfers are compared with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      foreach (heap_words[i]) heap_words[i] = 0;
      heap_wr(4, 8 | ALLOC_BIT);
      heap_wr(8, 8 | ALLOC_BIT);
      heap_wr(12, FIRST_CHUNK);
      heap_wr(16 + FIRST_CHUNK - 8, FIRST_CHUNK);
      heap_wr(16 + FIRST_CHUNK - 4, ALLOC_BIT);
      list_head   = 16;
      heap_top    = 16 + FIRST_CHUNK;
      chunk_bytes = DEFAULT_CHUNK;
      result_q.delete();
      fails = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) chunk_bytes = cfg_ch.grow_chunk_bytes;
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(predict_result(in_ch.opcode, in_ch.request_bytes,
                                          in_ch.block_address));
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result, address", out_ch.payload_address, 0);
        end else begin
          want = result_q.pop_front();
          if (out_ch.payload_address !== want.payload_address)
            report_mismatch("payload_address", out_ch.payload_address, want.payload_address);
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/explicit_free_list_best_fit_allocator_core_tb.sv
// Bench top of the best-fit allocator: clock, reset, stimulus and verdict.
// Depends on efla_pkg, efla_if.sv, efla_scoreboard and the allocator core.
`default_nettype none

module explicit_free_list_best_fit_allocator_core_tb;
  import efla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  bit   steady;
  logic [15:0] live_q [$];
  logic [15:0] freed_q [$];
  logic [15:0] last_payload;

  efla_cfg_if cfg_ch ();
  efla_in_if  in_ch ();
  efla_out_if out_ch ();

  explicit_free_list_best_fit_allocator_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  efla_scoreboard u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_ch      (cfg_ch),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.grow_chunk_bytes = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.block_address = '0;
  end

  // The receiver stalls at random except during the steady stretch.
  always @(posedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 31);
  end

  // Granted blocks are remembered so that frees can name them.
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      last_payload <= out_ch.payload_address;
      if (out_ch.payload_address != 0) live_q.push_back(out_ch.payload_address);
    end
  end

  // Watchdog over cycles in which no transfer happens on any channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL explicit_free_list_best_fit_allocator_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic op, logic [15:0] req, logic [15:0] addr);
    bit taken;
    while (!steady && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.request_bytes <= req;
    in_ch.block_address <= addr;
    do begin
      @(negedge clk_i);
      taken = in_ch.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Register write while idle; every request has a result, so a short
  // margin after the last result is enough.
  task automatic write_chunk(logic [16:0] value);
    bit taken;
    drain();
    repeat (50) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.grow_chunk_bytes <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ch.ready;
      @(posedge clk_i);
    end while (!taken);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic alloc_now(logic [15:0] req, output logic [15:0] addr);
    send_item(OP_ALLOC, req, 16'd0);
    drain();
    @(posedge clk_i);
    addr = last_payload;
  endtask

  task automatic free_now(logic [15:0] addr);
    int idx[$];
    idx = live_q.find_first_index(x) with (x == addr);
    if (idx.size() != 0) live_q.delete(idx[0]);
    freed_q.push_back(addr);
    send_item(OP_FREE, 16'd0, addr);
  endtask

  // One random request: mostly well-formed allocations and frees of live
  // blocks, with double frees, forged addresses and odd sizes mixed in.
  task automatic random_item();
    int unsigned pick, k;
    logic [15:0] a;
    pick = $urandom_range(99);
    if (pick < 55 || live_q.size() == 0) begin
      k = $urandom_range(99);
      if (k < 3) send_item(OP_ALLOC, 16'd0, 16'($urandom));
      else if (k < 8) send_item(OP_ALLOC, 16'($urandom), 16'($urandom));
      else if (k < 70) send_item(OP_ALLOC, 16'($urandom_range(64, 1)), 16'($urandom));
      else send_item(OP_ALLOC, 16'($urandom_range(2048, 1)), 16'($urandom));
    end else if (pick < 92) begin
      k = $urandom_range(live_q.size() - 1);
      a = live_q[k];
      live_q.delete(k);
      freed_q.push_back(a);
      send_item(OP_FREE, 16'($urandom), a);
    end else if (pick < 97 && freed_q.size() != 0) begin
      send_item(OP_FREE, 16'($urandom), freed_q[$urandom_range(freed_q.size() - 1)]);
    end else begin
      send_item(OP_FREE, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] a, b, c, d, e, f, g;
    logic [16:0] chunks [5];
    chunks = '{17'd16, 17'd65536, 17'd4096, 17'd200, 17'd0};
    steady = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: sizes at the edges, growth, every merge case, bad frees.
    write_chunk(17'd16);
    send_item(OP_ALLOC, 16'd0, 16'hFFFF);
    send_item(OP_ALLOC, 16'hFFFF, 16'd0);
    alloc_now(16'd1, a);
    alloc_now(16'd8, b);
    alloc_now(16'd9, c);
    alloc_now(16'd24, d);
    free_now(b);
    free_now(a);
    free_now(c);
    alloc_now(16'd16, e);
    alloc_now(16'd16, f);
    alloc_now(16'd16, g);
    free_now(e);
    free_now(g);
    free_now(f);
    free_now(f);
    send_item(OP_FREE, 16'd0, 16'd20);
    send_item(OP_FREE, 16'd0, 16'd8);
    send_item(OP_FREE, 16'd0, 16'hFFF8);
    alloc_now(16'd5000, a);
    alloc_now(16'd4000, b);
    free_now(d);

    // Random phases under different growth settings.
    for (int p = 0; p < 5; p++) begin
      write_chunk(p == 4 ? 17'($urandom_range(65536, 16)) : chunks[p]);
      for (int i = 0; i < 370; i++) begin
        steady = (p == 2 && i >= 50 && i < 250);
        if (p == 1 && i == 185) drain();
        random_item();
      end
      steady = 1'b0;
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS explicit_free_list_best_fit_allocator_core");
    end else begin
      $display("FAIL explicit_free_list_best_fit_allocator_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
